### hdl/lld_pkg.sv
// Shared types and codes for the least-loaded dispatcher.
// Used by every module of the block; it depends on nothing else.
`default_nettype none

package lld_pkg;

  // One request word as it arrives on the command port.
  typedef struct packed {
    logic [1:0] req_type;
    logic [5:0] source_id;
    logic       shared_mode;
    logic [2:0] done_worker;
  } req_t;

  // One result word.
  typedef struct packed {
    logic [1:0]  status;
    logic [2:0]  target_worker;
    logic [15:0] target_load;
  } rsp_t;

  localparam logic [1:0] REQ_REGISTER = 2'd0;
  localparam logic [1:0] REQ_REMOVE   = 2'd1;
  localparam logic [1:0] REQ_READY    = 2'd2;
  localparam logic [1:0] REQ_DONE     = 2'd3;

  localparam logic [1:0] ST_DONE       = 2'd0;
  localparam logic [1:0] ST_DISPATCHED = 2'd1;
  localparam logic [1:0] ST_UNKNOWN    = 2'd2;
  localparam logic [1:0] ST_ALREADY    = 2'd3;

  localparam logic [3:0] ACTIVE_RESET = 4'd8;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SRC,
    S_EVAL,
    S_SCAN,
    S_SCAN_END,
    S_LRD,
    S_LWR
  } state_t;

  typedef enum logic [1:0] {
    ALU_LT,
    ALU_INC,
    ALU_DEC
  } alu_op_t;

endpackage

`default_nettype wire

### hdl/lld_alu.sv
// Shared compare and saturating increment/decrement unit for loads and counts.
// Depends on lld_pkg for the operation codes.
`default_nettype none

module lld_alu #(
  parameter int LOAD_BITS = 16
) (
  input  lld_pkg::alu_op_t       op,
  input  logic [LOAD_BITS-1:0]   a,
  input  logic [LOAD_BITS-1:0]   b,
  output logic [LOAD_BITS-1:0]   y,
  output logic                   lt
);
  import lld_pkg::*;

  always_comb begin
    lt = (a < b);
    case (op)
      ALU_LT: begin
        y = a;
      end
      ALU_INC: begin
        y = (a == '1) ? a : a + LOAD_BITS'(1);
      end
      ALU_DEC: begin
        y = (a == '0) ? a : a - LOAD_BITS'(1);
      end
      default: begin
        y = a;
      end
    endcase
  end

endmodule

`default_nettype wire

### hdl/lld_load_mem.sv
// Worker load memory: one write port, one registered read port.
// Per-entry valid bits make unwritten entries read as zero after reset.
`default_nettype none

module lld_load_mem #(
  parameter int WORKERS   = 8,
  parameter int LOAD_BITS = 16,
  localparam int WIDX     = (WORKERS > 1) ? $clog2(WORKERS) : 1
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic [WIDX-1:0]      rd_addr,
  output logic [LOAD_BITS-1:0] rd_data,
  input  logic                 wr_en,
  input  logic [WIDX-1:0]      wr_addr,
  input  logic [LOAD_BITS-1:0] wr_data
);
  import lld_pkg::*;

  logic [LOAD_BITS-1:0] mem [WORKERS];
  logic [WORKERS-1:0]   written;

  always_ff @(posedge clk) begin
    if (rst) begin
      written <= '0;
    end else if (wr_en) begin
      written[wr_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= written[rd_addr] ? mem[rd_addr] : '0;
  end

endmodule

`default_nettype wire

### hdl/lld_src_table.sv
// Source table memory holding valid, shared, in-flight count and home worker.
// Runs a clearing pass over every entry after reset; depends on lld_pkg.
`default_nettype none

module lld_src_table #(
  parameter int SOURCES = 64,
  parameter int ENT_W   = 21,
  localparam int SRC_AW = (SOURCES > 1) ? $clog2(SOURCES) : 1
) (
  input  logic              clk,
  input  logic              rst,
  input  logic [SRC_AW-1:0] rd_addr,
  output logic [ENT_W-1:0]  rd_data,
  input  logic              wr_en,
  input  logic [SRC_AW-1:0] wr_addr,
  input  logic [ENT_W-1:0]  wr_data,
  output logic              clearing
);
  import lld_pkg::*;

  localparam logic [SRC_AW-1:0] LAST_IDX = SRC_AW'(SOURCES - 1);

  logic [ENT_W-1:0]  mem [SOURCES];
  logic [SRC_AW-1:0] clr_idx;

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_idx  <= '0;
    end else if (clearing) begin
      clr_idx <= clr_idx + SRC_AW'(1);
      if (clr_idx == LAST_IDX) begin
        clearing <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (clearing) begin
      mem[clr_idx] <= '0;
    end else if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

  // The pass must have reached the last entry before it ends.
  a_clear_complete : assert property (@(posedge clk) disable iff (rst)
    $fell(clearing) |-> $past(clr_idx) == LAST_IDX)
    else $error("source table clearing pass ended early");

endmodule

`default_nettype wire

### hdl/least_loaded_dispatch_with_affinity.sv
// Top level of the least-loaded dispatcher with per-source affinity.
// Holds the sequencer; uses lld_pkg, lld_src_table, lld_load_mem and lld_alu.
//
//   Port group        Dir  Handshake         Word
//   start/req/busy    in   start & !busy     lld_pkg::req_t
//   result_valid      out  one-cycle strobe  lld_pkg::rsp_t on result
//   cfg_we/cfg_wdata  in   cfg_we            active_workers
//
// A ready event that needs a least-loaded search walks S_SRC, S_EVAL, S_SCAN over the
// active workers, S_SCAN_END, S_LRD and S_LWR: the load memory has a single read port and
// the scan reads and compares one worker per cycle. Pinned dispatch to a home worker and
// completions skip the scan; register and remove finish in S_EVAL. After reset the source
// table runs a clearing pass over every entry, during which busy is high. The result
// strobe comes in the cycle after the last busy cycle; the receiver cannot stall.
`default_nettype none

module least_loaded_dispatch_with_affinity #(
  parameter int WORKERS   = 8,
  parameter int SOURCES   = 64,
  parameter int LOAD_BITS = 16
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  input  lld_pkg::req_t  req,
  output logic           busy,
  output logic           result_valid,
  output lld_pkg::rsp_t  result,
  input  logic           cfg_we,
  input  logic [3:0]     cfg_wdata
);
  import lld_pkg::*;

  localparam int WIDX   = (WORKERS > 1) ? $clog2(WORKERS) : 1;
  localparam int SRC_AW = (SOURCES > 1) ? $clog2(SOURCES) : 1;
  localparam int ENT_W  = 2 + LOAD_BITS + WIDX;

  state_t state, state_next;

  req_t                 req_q;
  logic [3:0]           active_workers;
  logic [WIDX-1:0]      last_w;
  logic [WIDX-1:0]      scan_idx;
  logic [WIDX-1:0]      cmp_idx;
  logic                 cmp_en;
  logic [WIDX-1:0]      best_idx;
  logic [LOAD_BITS-1:0] best_load;
  logic [WIDX-1:0]      target;
  logic                 take;

  logic                 clearing;
  logic [ENT_W-1:0]     src_rdata;
  logic                 src_we;
  logic [ENT_W-1:0]     src_wdata;
  logic                 ent_valid;
  logic                 ent_shared;
  logic [LOAD_BITS-1:0] ent_infl;
  logic [WIDX-1:0]      ent_home;
  logic                 in_range;
  logic                 known;
  logic                 dw_ok;

  logic [WIDX-1:0]      ld_raddr;
  logic [LOAD_BITS-1:0] ld_rdata;
  logic                 ld_we;

  alu_op_t              alu_op;
  logic [LOAD_BITS-1:0] alu_a;
  logic [LOAD_BITS-1:0] alu_y;
  logic                 alu_lt;

  logic                 finish;
  rsp_t                 fin_rsp;

  lld_src_table #(
    .SOURCES (SOURCES),
    .ENT_W   (ENT_W)
  ) u_src (
    .clk      (clk),
    .rst      (rst),
    .rd_addr  (SRC_AW'(req_q.source_id)),
    .rd_data  (src_rdata),
    .wr_en    (src_we),
    .wr_addr  (SRC_AW'(req_q.source_id)),
    .wr_data  (src_wdata),
    .clearing (clearing)
  );

  lld_load_mem #(
    .WORKERS   (WORKERS),
    .LOAD_BITS (LOAD_BITS)
  ) u_load (
    .clk     (clk),
    .rst     (rst),
    .rd_addr (ld_raddr),
    .rd_data (ld_rdata),
    .wr_en   (ld_we),
    .wr_addr (target),
    .wr_data (alu_y)
  );

  lld_alu #(
    .LOAD_BITS (LOAD_BITS)
  ) u_alu (
    .op (alu_op),
    .a  (alu_a),
    .b  (best_load),
    .y  (alu_y),
    .lt (alu_lt)
  );

  assign busy       = clearing || (state != S_IDLE);
  assign ent_valid  = src_rdata[ENT_W-1];
  assign ent_shared = src_rdata[ENT_W-2];
  assign ent_infl   = src_rdata[LOAD_BITS+WIDX-1:WIDX];
  assign ent_home   = src_rdata[WIDX-1:0];
  assign in_range   = 32'(req_q.source_id) < SOURCES;
  assign known      = in_range && ent_valid;
  assign dw_ok      = 32'(req_q.done_worker) < WORKERS;
  // Strict less-than keeps the lowest index on a tie.
  assign take       = (cmp_idx == '0) || alu_lt;

  // Highest worker index taking part, with the register limited to 1 .. WORKERS.
  always_comb begin
    if (active_workers == '0) begin
      last_w = '0;
    end else if (32'(active_workers) > WORKERS) begin
      last_w = WIDX'(WORKERS - 1);
    end else begin
      last_w = WIDX'(active_workers - 4'd1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    src_we     = 1'b0;
    src_wdata  = src_rdata;
    ld_raddr   = target;
    ld_we      = 1'b0;
    alu_op     = ALU_LT;
    alu_a      = ld_rdata;
    finish     = 1'b0;
    fin_rsp    = '0;
    case (state)
      S_IDLE: begin
        if (start && !clearing) begin
          state_next = S_SRC;
        end
      end
      S_SRC: begin
        state_next = S_EVAL;
      end
      S_EVAL: begin
        case (req_q.req_type)
          REQ_REGISTER: begin
            finish     = 1'b1;
            state_next = S_IDLE;
            if (!in_range) begin
              fin_rsp.status = ST_UNKNOWN;
            end else if (ent_valid) begin
              fin_rsp.status = ST_ALREADY;
            end else begin
              src_we    = 1'b1;
              src_wdata = {1'b1, req_q.shared_mode, {LOAD_BITS{1'b0}}, {WIDX{1'b0}}};
            end
          end
          REQ_REMOVE: begin
            finish     = 1'b1;
            state_next = S_IDLE;
            if (!known) begin
              fin_rsp.status = ST_UNKNOWN;
            end else begin
              src_we    = 1'b1;
              src_wdata = {1'b0, src_rdata[ENT_W-2:0]};
            end
          end
          REQ_READY: begin
            if (!known) begin
              finish         = 1'b1;
              fin_rsp.status = ST_UNKNOWN;
              state_next     = S_IDLE;
            end else if (!ent_shared && (ent_infl != '0)) begin
              state_next = S_LRD;
            end else begin
              state_next = S_SCAN;
            end
          end
          default: begin
            alu_op = ALU_DEC;
            alu_a  = ent_infl;
            if (known && !ent_shared) begin
              src_we    = 1'b1;
              src_wdata = {1'b1, 1'b0, alu_y, ent_home};
            end
            if (dw_ok) begin
              state_next = S_LRD;
            end else begin
              finish     = 1'b1;
              state_next = S_IDLE;
            end
          end
        endcase
      end
      S_SCAN: begin
        ld_raddr = scan_idx;
        if (scan_idx == last_w) begin
          state_next = S_SCAN_END;
        end
      end
      S_SCAN_END: begin
        state_next = S_LRD;
      end
      S_LRD: begin
        alu_op = ALU_INC;
        alu_a  = ent_infl;
        if ((req_q.req_type == REQ_READY) && !ent_shared) begin
          src_we    = 1'b1;
          src_wdata = {1'b1, 1'b0, alu_y, target};
        end
        state_next = S_LWR;
      end
      S_LWR: begin
        alu_op     = (req_q.req_type == REQ_READY) ? ALU_INC : ALU_DEC;
        ld_we      = 1'b1;
        finish     = 1'b1;
        state_next = S_IDLE;
        if (req_q.req_type == REQ_READY) begin
          fin_rsp.status        = ST_DISPATCHED;
          fin_rsp.target_worker = 3'(target);
          fin_rsp.target_load   = 16'(alu_y);
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active_workers <= ACTIVE_RESET;
      result_valid   <= 1'b0;
      cmp_en         <= 1'b0;
    end else begin
      if (cfg_we) begin
        active_workers <= cfg_wdata;
      end
      result_valid <= finish;
      cmp_en       <= (state == S_SCAN);
    end
  end

  always_ff @(posedge clk) begin
    if ((state == S_IDLE) && start && !busy) begin
      req_q <= req;
    end
    cmp_idx <= scan_idx;
    if (state == S_EVAL) begin
      scan_idx <= '0;
      target   <= (req_q.req_type == REQ_READY) ? ent_home : WIDX'(req_q.done_worker);
    end
    if (state == S_SCAN) begin
      scan_idx <= scan_idx + WIDX'(1);
    end
    if (cmp_en && take) begin
      best_idx  <= cmp_idx;
      best_load <= ld_rdata;
    end
    if (state == S_SCAN_END) begin
      target <= take ? cmp_idx : best_idx;
    end
    if (finish) begin
      result <= fin_rsp;
    end
  end

  a_strobe_single : assert property (@(posedge clk) disable iff (rst)
    result_valid |=> !result_valid)
    else $error("result strobe held for more than one cycle");

  a_accept_starts : assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> (state == S_SRC))
    else $error("accepted word did not start the sequence");

  a_quiet_fields : assert property (@(posedge clk) disable iff (rst)
    (result_valid && (result.status != ST_DISPATCHED)) |->
      (result.target_worker == '0) && (result.target_load == '0))
    else $error("non-dispatch result carries a worker or load");

  a_scan_last_compare : assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN_END) |-> cmp_en)
    else $error("scan ended without its final compare");

endmodule

`default_nettype wire

### bench/tb.sv
`timescale 1ns / 1ps
// Self-checking bench for least_loaded_dispatch_with_affinity: directed cases, random
// phases over several worker counts, then a pinned burst. Depends on lld_pkg and the RTL.
module tb;
  import lld_pkg::*;

  localparam int WORKERS = 8;
  localparam int SOURCES = 64;
  localparam logic [15:0] LOAD_MAX = 16'hFFFF;
  localparam int CYCLE_LIMIT = 4_000_000;
  localparam int SETTLE_CYCLES = 16;

  logic       clk;
  logic       rst;
  logic       start;
  req_t       req;
  logic       busy;
  logic       result_valid;
  rsp_t       result;
  logic       cfg_we;
  logic [3:0] cfg_wdata;

  least_loaded_dispatch_with_affinity u_top (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .req          (req),
    .busy         (busy),
    .result_valid (result_valid),
    .result       (result),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata)
  );

  // Mirror of the dispatcher's tables, updated as each word is accepted.
  logic        src_valid_m   [SOURCES];
  logic        src_shared_m  [SOURCES];
  logic [15:0] src_flight_m  [SOURCES];
  logic [2:0]  src_home_m    [SOURCES];
  logic [15:0] worker_load_m [WORKERS];
  logic [3:0]  active_m;

  rsp_t       expected_words[$];
  rsp_t       want;
  logic [5:0] hot_ids[8];
  int         fails;
  int         words_sent;
  int         dispatches;
  int         settings_used;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic [15:0] sat_up(logic [15:0] v);
    return (v == LOAD_MAX) ? v : v + 16'd1;
  endfunction

  function automatic logic [15:0] sat_down(logic [15:0] v);
    return (v == 16'd0) ? v : v - 16'd1;
  endfunction

  function automatic logic [2:0] least_loaded_worker();
    int n;
    int best;
    n = (active_m < 4'd1) ? 1 : (active_m > WORKERS) ? WORKERS : int'(active_m);
    best = 0;
    for (int i = 1; i < n; i++) begin
      if (worker_load_m[i] < worker_load_m[best]) best = i;
    end
    return best[2:0];
  endfunction

  function automatic rsp_t predict_dispatch(req_t w);
    rsp_t       r;
    logic [2:0] tgt;
    int         s;
    s = w.source_id;
    r = '0;
    r.status = ST_DONE;
    case (w.req_type)
      REQ_REGISTER: begin
        if (src_valid_m[s]) begin
          r.status = ST_ALREADY;
        end else begin
          src_valid_m[s]  = 1'b1;
          src_shared_m[s] = w.shared_mode;
          src_flight_m[s] = '0;
          src_home_m[s]   = '0;
        end
      end
      REQ_REMOVE: begin
        if (!src_valid_m[s]) r.status = ST_UNKNOWN;
        else src_valid_m[s] = 1'b0;
      end
      REQ_READY: begin
        if (!src_valid_m[s]) begin
          r.status = ST_UNKNOWN;
        end else begin
          if (src_shared_m[s]) begin
            tgt = least_loaded_worker();
          end else begin
            // A pinned source sticks to its home while anything is in flight,
            // even if that home has fallen outside the active workers.
            if (src_flight_m[s] != 16'd0) begin
              tgt = src_home_m[s];
            end else begin
              tgt = least_loaded_worker();
              src_home_m[s] = tgt;
            end
            src_flight_m[s] = sat_up(src_flight_m[s]);
          end
          worker_load_m[tgt] = sat_up(worker_load_m[tgt]);
          r.status        = ST_DISPATCHED;
          r.target_worker = tgt;
          r.target_load   = worker_load_m[tgt];
        end
      end
      REQ_DONE: begin
        worker_load_m[w.done_worker] = sat_down(worker_load_m[w.done_worker]);
        if (src_valid_m[s] && !src_shared_m[s]) src_flight_m[s] = sat_down(src_flight_m[s]);
      end
    endcase
    return r;
  endfunction

  function automatic req_t mk_word(logic [1:0] kind, logic [5:0] sid, logic shared,
                                   logic [2:0] dw);
    req_t w;
    w.req_type    = kind;
    w.source_id   = sid;
    w.shared_mode = shared;
    w.done_worker = dw;
    return w;
  endfunction

  // Mostly well-formed traffic on a few busy sources, with some pure noise.
  function automatic req_t random_word();
    req_t w;
    int   pick;
    int   s;
    w = req_t'(12'($urandom));
    pick = $urandom_range(99);
    if (pick < 10) return w;
    w.source_id = hot_ids[$urandom_range(7)];
    s = w.source_id;
    if (pick < 22) w.req_type = REQ_REGISTER;
    else if (pick < 28) w.req_type = REQ_REMOVE;
    else if (pick < 64) w.req_type = REQ_READY;
    else w.req_type = REQ_DONE;
    if (w.req_type == REQ_DONE && src_valid_m[s] && !src_shared_m[s] &&
        src_flight_m[s] != 16'd0 && $urandom_range(9) < 7) begin
      w.done_worker = src_home_m[s];
    end
    return w;
  endfunction

  task automatic reset_mirror();
    for (int i = 0; i < SOURCES; i++) begin
      src_valid_m[i]  = 1'b0;
      src_shared_m[i] = 1'b0;
      src_flight_m[i] = '0;
      src_home_m[i]   = '0;
    end
    for (int i = 0; i < WORKERS; i++) worker_load_m[i] = '0;
    active_m = ACTIVE_RESET;
  endtask

  // Entered just after a rising edge; the word is taken at the edge where busy is low.
  task automatic send_word(input req_t w);
    rsp_t r;
    @(negedge clk);
    start <= 1'b1;
    req   <= w;
    do @(posedge clk); while (busy);
    r = predict_dispatch(w);
    expected_words.insert(expected_words.size(), r);
    words_sent++;
    if (r.status == ST_DISPATCHED) dispatches++;
  endtask

  task automatic pause_sender(input int n);
    @(negedge clk);
    start <= 1'b0;
    repeat (n - 1) @(negedge clk);
  endtask

  task automatic wait_drained();
    pause_sender(1);
    while (expected_words.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_active(input logic [3:0] v);
    wait_drained();
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_we <= 1'b0;
    active_m = v;
    settings_used++;
  endtask

  task automatic test_register_remove();
    send_word(mk_word(REQ_REGISTER, 6'd0, 1'b1, 3'd0));
    send_word(mk_word(REQ_REGISTER, 6'd0, 1'b0, 3'd7));
    send_word(mk_word(REQ_REGISTER, 6'd63, 1'b0, 3'd0));
    send_word(mk_word(REQ_REMOVE, 6'd5, 1'b0, 3'd0));
    send_word(mk_word(REQ_READY, 6'd5, 1'b1, 3'd7));
    send_word(mk_word(REQ_DONE, 6'd5, 1'b0, 3'd7));
  endtask

  // With all loads equal the lowest index wins, so seven words fill workers 0 to 6.
  task automatic test_shared_spread();
    repeat (7) send_word(mk_word(REQ_READY, 6'd0, 1'b0, 3'd0));
  endtask

  task automatic test_pinned_home();
    send_word(mk_word(REQ_READY, 6'd63, 1'b0, 3'd0));
    write_active(4'd2);
    send_word(mk_word(REQ_READY, 6'd63, 1'b1, 3'd0));
    send_word(mk_word(REQ_DONE, 6'd63, 1'b0, 3'd7));
    send_word(mk_word(REQ_DONE, 6'd63, 1'b1, 3'd7));
    send_word(mk_word(REQ_DONE, 6'd63, 1'b0, 3'd7));
    send_word(mk_word(REQ_READY, 6'd63, 1'b0, 3'd0));
    send_word(mk_word(REQ_REMOVE, 6'd63, 1'b0, 3'd0));
    send_word(mk_word(REQ_DONE, 6'd63, 1'b0, 3'd0));
    send_word(mk_word(REQ_REMOVE, 6'd63, 1'b0, 3'd0));
    send_word(mk_word(REQ_REGISTER, 6'd63, 1'b1, 3'd0));
    send_word(mk_word(REQ_READY, 6'd63, 1'b0, 3'd0));
  endtask

  task automatic test_random(input int count, input logic [3:0] workers, input int gap_pct);
    write_active(workers);
    for (int i = 0; i < 8; i++) hot_ids[i] = 6'($urandom_range(63));
    repeat (count) begin
      if ($urandom_range(99) < gap_pct) pause_sender($urandom_range(1, 8));
      if ($urandom_range(199) == 0) wait_drained();
      send_word(random_word());
    end
  endtask

  // Back-to-back dispatches to one pinned source on two workers, then completions
  // named at its home, so the in-flight count climbs and falls without a gap.
  task automatic test_pinned_burst();
    write_active(4'd2);
    send_word(mk_word(REQ_REMOVE, 6'd40, 1'b0, 3'd0));
    send_word(mk_word(REQ_REGISTER, 6'd40, 1'b0, 3'd0));
    repeat (30) send_word(mk_word(REQ_READY, 6'd40, 1'b0, 3'd0));
    repeat (3) send_word(mk_word(REQ_DONE, 6'd40, 1'b0, src_home_m[40]));
    send_word(mk_word(REQ_READY, 6'd40, 1'b0, 3'd0));
  endtask

  always @(posedge clk) begin
    if (!rst && result_valid) begin
      if (expected_words.size() == 0) begin
        fails++;
        $display("%0t: unexpected word: expected none, got st %0d wk %0d ld %0d",
                 $time, result.status, result.target_worker, result.target_load);
      end else begin
        want = expected_words.pop_front();
        if (result.status !== want.status || result.target_worker !== want.target_worker ||
            result.target_load !== want.target_load) begin
          fails++;
          $display("%0t: expected st %0d wk %0d ld %0d, got st %0d wk %0d ld %0d",
                   $time, want.status, want.target_worker, want.target_load,
                   result.status, result.target_worker, result.target_load);
        end
      end
    end
  end

  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("Run stopped at the cycle limit with %0d result words outstanding.",
             expected_words.size());
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    rst           = 1'b1;
    start         = 1'b0;
    req           = '0;
    cfg_we        = 1'b0;
    cfg_wdata     = '0;
    fails         = 0;
    words_sent    = 0;
    dispatches    = 0;
    settings_used = 0;
    reset_mirror();
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_register_remove();
    test_shared_spread();
    test_pinned_home();
    test_random(230, 4'd8, 0);
    test_random(230, 4'd1, 59);
    test_random(230, 4'd3, 14);
    test_random(230, 4'd0, 59);
    test_random(230, 4'd15, 0);
    test_random(230, 4'd5, 14);
    test_pinned_burst();
    wait_drained();

    $display("Sent %0d command words (%0d dispatches) over %0d worker-count settings,",
             words_sent, dispatches, settings_used);
    $display("including pinned homes, removals, unknown sources and bursts; %0d failures.",
             fails);
    if (fails == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
